// ----- hw/rtl/conv2d_correlation_valid_full_defines.svh -----
// Assertion macros for the 2D correlation block.
// Included by the top level; depends on nothing else.
`ifndef CONV2D_CORRELATION_VALID_FULL_DEFINES_SVH
`define CONV2D_CORRELATION_VALID_FULL_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define C2D_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define C2D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/c2d_pkg.sv -----
// Package for the 2D correlation block: widths, register indexes, codes and
// the control types shared by the controller and the datapath. No dependencies.
package c2d_pkg;

  localparam int unsigned MaxImageDim  = 32;
  localparam int unsigned MaxKernelDim = 8;

  localparam int unsigned CmdW     = 2;
  localparam int unsigned PosW     = 6;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned ProdW    = 32;
  localparam int unsigned SumW     = 40;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 6;
  localparam int unsigned ImgDimW  = 6;
  localparam int unsigned KerDimW  = 4;

  localparam logic [CfgIdxW-1:0] RegImageRows  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegImageCols  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKernelRows = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKernelCols = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFullMode   = 3'd4;

  localparam logic [ImgDimW-1:0] ImageRowsRst  = 6'd32;
  localparam logic [ImgDimW-1:0] ImageColsRst  = 6'd32;
  localparam logic [KerDimW-1:0] KernelRowsRst = 4'd3;
  localparam logic [KerDimW-1:0] KernelColsRst = 4'd3;
  localparam logic               FullModeRst   = 1'b0;

  typedef enum logic [CmdW-1:0] {
    CMD_WR_KERNEL = 2'd0,
    CMD_WR_IMAGE  = 2'd1,
    CMD_COMPUTE   = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic wr_kernel;
    logic wr_image;
    logic start;
    logic tap_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic bad_pos;
    logic tap_last;
  } dp_status_t;

endpackage

// ----- hw/rtl/c2d_if.sv -----
// Handshake interfaces for the configuration, request and result channels.
// Depends on c2d_pkg for the payload widths.
interface c2d_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [c2d_pkg::CfgIdxW-1:0]      index;
  logic [c2d_pkg::CfgDataW-1:0]     wdata;
  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

interface c2d_in_if;
  logic                             valid;
  logic                             ready;
  logic [c2d_pkg::CmdW-1:0]         command;
  logic [c2d_pkg::PosW-1:0]         pos_row;
  logic [c2d_pkg::PosW-1:0]         pos_col;
  logic signed [c2d_pkg::SampleW-1:0] sample;
  modport source (output valid, command, pos_row, pos_col, sample, input ready);
  modport sink   (input valid, command, pos_row, pos_col, sample, output ready);
endinterface

interface c2d_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [c2d_pkg::SumW-1:0]  corr_sum;
  logic                             bad_position;
  modport source (output valid, corr_sum, bad_position, input ready);
  modport sink   (input valid, corr_sum, bad_position, output ready);
endinterface

// ----- hw/rtl/c2d_ctrl.sv -----
// Controller for the 2D correlation block: sequences loads, the tap walk and
// the result register. Depends on c2d_pkg.
module c2d_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic [c2d_pkg::CmdW-1:0] command_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  input  c2d_pkg::dp_status_t      status_i,
  output c2d_pkg::dp_cmd_t         cmd_o
);

  c2d_pkg::ctrl_state_e state_q, state_d;
  logic                 out_valid_q, out_valid_d;
  logic                 accept;
  logic                 is_compute;
  logic                 out_free;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    is_compute = 1'b0;
    case (c2d_pkg::cmd_e'(command_i))
      c2d_pkg::CMD_COMPUTE: is_compute = 1'b1;
      default:              is_compute = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      c2d_pkg::ST_IDLE: begin
        if (accept && is_compute) begin
          state_d = status_i.bad_pos ? c2d_pkg::ST_DONE : c2d_pkg::ST_RUN;
        end
      end
      c2d_pkg::ST_RUN: begin
        if (status_i.tap_last) begin
          state_d = c2d_pkg::ST_DRAIN1;
        end
      end
      c2d_pkg::ST_DRAIN1: state_d = c2d_pkg::ST_DRAIN2;
      c2d_pkg::ST_DRAIN2: state_d = c2d_pkg::ST_DONE;
      c2d_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = c2d_pkg::ST_IDLE;
        end
      end
      default: state_d = c2d_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o.wr_kernel = 1'b0;
    cmd_o.wr_image  = 1'b0;
    cmd_o.start     = 1'b0;
    cmd_o.tap_step  = 1'b0;
    cmd_o.out_load  = 1'b0;
    case (state_q)
      c2d_pkg::ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.wr_kernel = in_valid_i &&
                          (command_i == c2d_pkg::CMD_WR_KERNEL);
        cmd_o.wr_image  = in_valid_i &&
                          (command_i == c2d_pkg::CMD_WR_IMAGE);
        cmd_o.start     = in_valid_i && is_compute;
      end
      c2d_pkg::ST_RUN:  cmd_o.tap_step = 1'b1;
      c2d_pkg::ST_DONE: cmd_o.out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= c2d_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- hw/rtl/c2d_datapath.sv -----
// Datapath for the 2D correlation block: configuration registers, image and
// kernel memories, the tap counters and the shared multiply-accumulate.
// Depends on c2d_pkg.
module c2d_datapath #(
  parameter int unsigned MAX_IMAGE_DIM  = c2d_pkg::MaxImageDim,
  parameter int unsigned MAX_KERNEL_DIM = c2d_pkg::MaxKernelDim
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  c2d_pkg::dp_cmd_t                    cmd_i,
  output c2d_pkg::dp_status_t                 status_o,
  input  logic [c2d_pkg::PosW-1:0]            pos_row_i,
  input  logic [c2d_pkg::PosW-1:0]            pos_col_i,
  input  logic signed [c2d_pkg::SampleW-1:0]  sample_i,
  input  logic                                cfg_we_i,
  input  logic [c2d_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [c2d_pkg::CfgDataW-1:0]        cfg_data_i,
  output logic signed [c2d_pkg::SumW-1:0]     corr_sum_o,
  output logic                                bad_position_o
);

  localparam int unsigned RowW     = $clog2(MAX_IMAGE_DIM);
  localparam int unsigned KIdxW    = (MAX_KERNEL_DIM > 1) ? $clog2(MAX_KERNEL_DIM) : 1;
  localparam int unsigned CmpW     = $clog2(MAX_IMAGE_DIM + MAX_KERNEL_DIM + 64) + 2;
  localparam int unsigned ImgDepth = 2 ** (2 * RowW);
  localparam int unsigned KerDepth = 2 ** (2 * KIdxW);

  function automatic logic [CmpW-1:0] clamp_dim(logic [CmpW-1:0] v, logic [CmpW-1:0] maxd);
    logic [CmpW-1:0] r;
    if (v == '0) begin
      r = CmpW'(1);
    end else if (v > maxd) begin
      r = maxd;
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [c2d_pkg::ImgDimW-1:0] image_rows_q, image_cols_q;
  logic [c2d_pkg::KerDimW-1:0] kernel_rows_q, kernel_cols_q;
  logic                        full_mode_q;

  logic signed [CmpW-1:0] ir_s, ic_s, kr_s, kc_s, kr_m1, kc_m1;
  logic signed [CmpW-1:0] orows_s, ocols_s, offr_s, offc_s, rin_s, cin_s;
  logic signed [CmpW-1:0] y_s, x_s;
  logic                   tap_in;
  logic                   l_wrap;

  logic [c2d_pkg::PosW-1:0] r_q, c_q;
  logic [KIdxW-1:0]         k_q, l_q;
  logic                     bad_q;

  logic [c2d_pkg::SampleW-1:0] img_mem [ImgDepth];
  logic [c2d_pkg::SampleW-1:0] ker_mem [KerDepth];
  logic [2*RowW-1:0]           img_wr_addr, img_rd_addr;
  logic [2*KIdxW-1:0]          ker_wr_addr, ker_rd_addr;
  logic                        img_wr_ok, ker_wr_ok;
  logic [c2d_pkg::SampleW-1:0] img_rd_q, ker_rd_q;

  logic                          s1_v_q, s1_in_q, s2_v_q;
  logic signed [c2d_pkg::ProdW-1:0] prod_d, prod_q;
  logic signed [c2d_pkg::SumW-1:0]  acc_q;
  logic signed [c2d_pkg::SumW-1:0]  corr_sum_q;
  logic                             bad_position_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_rows_q  <= c2d_pkg::ImageRowsRst;
      image_cols_q  <= c2d_pkg::ImageColsRst;
      kernel_rows_q <= c2d_pkg::KernelRowsRst;
      kernel_cols_q <= c2d_pkg::KernelColsRst;
      full_mode_q   <= c2d_pkg::FullModeRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        c2d_pkg::RegImageRows:  image_rows_q  <= cfg_data_i;
        c2d_pkg::RegImageCols:  image_cols_q  <= cfg_data_i;
        c2d_pkg::RegKernelRows: kernel_rows_q <= cfg_data_i[c2d_pkg::KerDimW-1:0];
        c2d_pkg::RegKernelCols: kernel_cols_q <= cfg_data_i[c2d_pkg::KerDimW-1:0];
        c2d_pkg::RegFullMode:   full_mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign ir_s  = $signed(clamp_dim(CmpW'(image_rows_q), CmpW'(MAX_IMAGE_DIM)));
  assign ic_s  = $signed(clamp_dim(CmpW'(image_cols_q), CmpW'(MAX_IMAGE_DIM)));
  assign kr_s  = $signed(clamp_dim(CmpW'(kernel_rows_q), CmpW'(MAX_KERNEL_DIM)));
  assign kc_s  = $signed(clamp_dim(CmpW'(kernel_cols_q), CmpW'(MAX_KERNEL_DIM)));
  assign kr_m1 = kr_s - CmpW'(1);
  assign kc_m1 = kc_s - CmpW'(1);

  assign orows_s = full_mode_q ? (ir_s + kr_m1) : (ir_s - kr_m1);
  assign ocols_s = full_mode_q ? (ic_s + kc_m1) : (ic_s - kc_m1);
  assign offr_s  = full_mode_q ? kr_m1 : '0;
  assign offc_s  = full_mode_q ? kc_m1 : '0;

  assign rin_s = $signed(CmpW'(pos_row_i));
  assign cin_s = $signed(CmpW'(pos_col_i));
  assign status_o.bad_pos = (rin_s >= orows_s) || (cin_s >= ocols_s);

  assign l_wrap            = ($signed(CmpW'(l_q)) == kc_m1);
  assign status_o.tap_last = l_wrap && ($signed(CmpW'(k_q)) == kr_m1);

  assign y_s    = $signed(CmpW'(r_q)) + $signed(CmpW'(k_q)) - offr_s;
  assign x_s    = $signed(CmpW'(c_q)) + $signed(CmpW'(l_q)) - offc_s;
  assign tap_in = (y_s >= 0) && (y_s < ir_s) && (x_s >= 0) && (x_s < ic_s);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      r_q   <= pos_row_i;
      c_q   <= pos_col_i;
      bad_q <= status_o.bad_pos;
      k_q   <= '0;
      l_q   <= '0;
    end else if (cmd_i.tap_step) begin
      if (l_wrap) begin
        l_q <= '0;
        k_q <= k_q + KIdxW'(1);
      end else begin
        l_q <= l_q + KIdxW'(1);
      end
    end
  end

  assign img_wr_ok   = (CmpW'(pos_row_i) < CmpW'(MAX_IMAGE_DIM)) &&
                       (CmpW'(pos_col_i) < CmpW'(MAX_IMAGE_DIM));
  assign ker_wr_ok   = (CmpW'(pos_row_i) < CmpW'(MAX_KERNEL_DIM)) &&
                       (CmpW'(pos_col_i) < CmpW'(MAX_KERNEL_DIM));
  assign img_wr_addr = {RowW'(pos_row_i), RowW'(pos_col_i)};
  assign ker_wr_addr = {KIdxW'(pos_row_i), KIdxW'(pos_col_i)};
  assign img_rd_addr = {y_s[RowW-1:0], x_s[RowW-1:0]};
  assign ker_rd_addr = {k_q, l_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_image && img_wr_ok) begin
      img_mem[img_wr_addr] <= sample_i;
    end
    if (cmd_i.tap_step) begin
      img_rd_q <= img_mem[img_rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_kernel && ker_wr_ok) begin
      ker_mem[ker_wr_addr] <= sample_i;
    end
    if (cmd_i.tap_step) begin
      ker_rd_q <= ker_mem[ker_rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s1_in_q <= 1'b0;
      s2_v_q  <= 1'b0;
    end else begin
      s1_v_q  <= cmd_i.tap_step;
      s1_in_q <= tap_in;
      s2_v_q  <= s1_v_q;
    end
  end

  assign prod_d = $signed(img_rd_q) * $signed(ker_rd_q);

  always_ff @(posedge clk_i) begin
    prod_q <= s1_in_q ? prod_d : '0;
    if (cmd_i.start) begin
      acc_q <= '0;
    end else if (s2_v_q) begin
      acc_q <= acc_q + c2d_pkg::SumW'(prod_q);
    end
    if (cmd_i.out_load) begin
      corr_sum_q     <= bad_q ? '0 : acc_q;
      bad_position_q <= bad_q;
    end
  end

  assign corr_sum_o     = corr_sum_q;
  assign bad_position_o = bad_position_q;

endmodule

// ----- hw/rtl/conv2d_correlation_valid_full.sv -----
// Top level of the 2D cross-correlation block (valid and full modes).
// Depends on c2d_pkg, c2d_if, c2d_ctrl, c2d_datapath and the defines header.
//
// Channel  Direction  Payload
// cfg_i    in         index[2:0], wdata[5:0]
// in_i     in         command[1:0], pos_row[5:0], pos_col[5:0], sample[15:0]
// out_o    out        corr_sum[39:0], bad_position
//
// A load request is accepted while idle and leaves the block idle. A compute request occupies
// the block while the single shared multiply-accumulate walks one kernel tap per cycle in RUN,
// then drains through DRAIN1 and DRAIN2 to DONE; a bad position goes straight to DONE.
// Reset restores the configuration defaults; the stores hold no data until written.
// One finished result waits in the output register; a second result stalls until it is taken.
`include "conv2d_correlation_valid_full_defines.svh"

module conv2d_correlation_valid_full #(
  parameter int unsigned MAX_IMAGE_DIM  = c2d_pkg::MaxImageDim,
  parameter int unsigned MAX_KERNEL_DIM = c2d_pkg::MaxKernelDim
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  c2d_cfg_if.sink    cfg_i,
  c2d_in_if.sink     in_i,
  c2d_out_if.source  out_o
);

  c2d_pkg::dp_cmd_t    dp_cmd;
  c2d_pkg::dp_status_t dp_status;
  logic                cfg_we;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid && cfg_i.ready;

  c2d_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .command_i   (in_i.command),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  c2d_datapath #(
    .MAX_IMAGE_DIM  (MAX_IMAGE_DIM),
    .MAX_KERNEL_DIM (MAX_KERNEL_DIM)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .status_o       (dp_status),
    .pos_row_i      (in_i.pos_row),
    .pos_col_i      (in_i.pos_col),
    .sample_i       (in_i.sample),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_i.index),
    .cfg_data_i     (cfg_i.wdata),
    .corr_sum_o     (out_o.corr_sum),
    .bad_position_o (out_o.bad_position)
  );

  `C2D_ASSERT_IMPL(a_bad_is_zero, clk_i, rst_ni, out_o.valid && out_o.bad_position, out_o.corr_sum == '0, "bad position result carries a nonzero sum")
  `C2D_ASSERT_NEXT(a_compute_busy, clk_i, rst_ni, in_i.valid && in_i.ready && (in_i.command == c2d_pkg::CMD_COMPUTE), !in_i.ready, "request accepted while a compute is in flight")
  `C2D_ASSERT_NEXT(a_out_drains, clk_i, rst_ni, out_o.valid && out_o.ready && !dp_cmd.out_load, !out_o.valid, "result repeated after its transaction")

endmodule
